// File: rtl/core/connection_id_allocator_core_defines.svh
// Assertion macros for the connection identifier allocator checker.
// No dependencies; included by cia_checker.sv.
`ifndef CONNECTION_ID_ALLOCATOR_CORE_DEFINES_SVH
`define CONNECTION_ID_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define CIA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cia_checker: same-cycle property failed");

// next-cycle implication
`define CIA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cia_checker: next-cycle property failed");

`endif

// File: rtl/core/cia_pkg.sv
// Types and constants shared by the connection identifier allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cia_pkg;

  localparam int ID_W     = 9;
  localparam int CNT_W    = 9;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NONE_LIVE  = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]  granted_id;
    logic [CNT_W-1:0] live_count;
    status_t          status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture request, read top of free stack
    logic exec;  // commit state update and result
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/connection_id_allocator_core.sv
// Top level of the connection identifier allocator: controller plus datapath.
// Depends on cia_pkg, cia_ctrl, cia_dpath.
//
//   channel   direction  handshake            payload
//   request   in         start & !busy        req  (action, release_id)
//   result    out        done (one cycle)     rsp  (granted_id, live_count, status)
//
// The accept edge reads the top of the free stack into a register and enters
// S_EXEC; the edge that leaves S_EXEC commits counters and the result.
// The result shows on rsp for the cycle after that, with done high; a new
// request may be accepted in that same cycle. busy is high for the one cycle
// between accept and commit. Synchronous reset empties the stack and restarts
// ids at 1; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module connection_id_allocator_core #(
  parameter int MAX_IDS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cia_pkg::req_t req,
  output logic               done,
  output cia_pkg::rsp_t      rsp
);

  cia_pkg::cmd_t cmd;

  cia_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  cia_dpath #(
    .MAX_IDS (MAX_IDS)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

// File: rtl/core/cia_ctrl.sv
// Controller for the connection identifier allocator: two-state sequencer.
// Depends on cia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cia_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  output cia_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  assign busy     = (state == S_EXEC);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);

endmodule

`default_nettype wire

// File: rtl/core/cia_dpath.sv
// Datapath for the connection identifier allocator: free stack memory,
// counters and result register. Depends on cia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cia_dpath #(
  parameter int MAX_IDS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cia_pkg::cmd_t cmd,
  input  wire cia_pkg::req_t req,
  output cia_pkg::rsp_t      rsp
);

  localparam int CW = $clog2(MAX_IDS + 1);    // depth and live count
  localparam int NW = $clog2(MAX_IDS + 2);    // fresh counter, reaches MAX_IDS+1
  localparam int AW = $clog2(MAX_IDS);        // stack address
  localparam int XW = ((NW > cia_pkg::ID_W) ? NW : cia_pkg::ID_W) + 1;

  logic [cia_pkg::ID_W-1:0] stack_mem [MAX_IDS];

  logic [CW-1:0]            depth, depth_next;
  logic [NW-1:0]            next_fresh, next_fresh_next;
  logic [CW-1:0]            live, live_next;
  cia_pkg::req_t            req_q;
  logic [cia_pkg::ID_W-1:0] rd_data;
  cia_pkg::rsp_t            rsp_q;

  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic                     push;
  logic [cia_pkg::ID_W-1:0] granted;
  cia_pkg::status_t         status;
  logic                     id_in_range;
  logic                     id_is_last_fresh;

  assign rd_addr = AW'(depth - CW'(1));
  assign wr_addr = AW'(depth);

  assign id_in_range = (req_q.release_id != '0) &&
                       (XW'(req_q.release_id) <= XW'(MAX_IDS));
  assign id_is_last_fresh = (XW'(req_q.release_id) + XW'(1)) == XW'(next_fresh);

  always_comb begin
    depth_next      = depth;
    next_fresh_next = next_fresh;
    live_next       = live;
    push            = 1'b0;
    granted         = '0;
    status          = cia_pkg::ST_OK;
    if (req_q.action == cia_pkg::ACT_ALLOC) begin
      priority if (live == CW'(MAX_IDS)) begin
        status = cia_pkg::ST_EXHAUSTED;
      end else if (depth != '0) begin
        depth_next = depth - CW'(1);
        granted    = rd_data;
        live_next  = live + CW'(1);
      end else if (next_fresh <= NW'(MAX_IDS)) begin
        granted         = cia_pkg::ID_W'(next_fresh);
        next_fresh_next = next_fresh + NW'(1);
        live_next       = live + CW'(1);
      end else begin
        status = cia_pkg::ST_EXHAUSTED;
      end
    end else begin
      priority if (live == '0) begin
        status = cia_pkg::ST_NONE_LIVE;
      end else if (live == CW'(1)) begin
        // last connection gone: drop the stack, restart fresh ids
        live_next       = '0;
        depth_next      = '0;
        next_fresh_next = NW'(1);
      end else begin
        live_next = live - CW'(1);
        if (id_in_range) begin
          priority if (id_is_last_fresh) begin
            next_fresh_next = next_fresh - NW'(1);
          end else if (depth == CW'(MAX_IDS)) begin
            status = cia_pkg::ST_STACK_FULL;
          end else begin
            push       = 1'b1;
            depth_next = depth + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      next_fresh <= NW'(1);
      live       <= '0;
    end else if (cmd.exec) begin
      depth      <= depth_next;
      next_fresh <= next_fresh_next;
      live       <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req;
      rd_data <= stack_mem[rd_addr];
    end
    if (cmd.exec && push) begin
      stack_mem[wr_addr] <= req_q.release_id;
    end
    if (cmd.exec) begin
      rsp_q.granted_id <= granted;
      rsp_q.live_count <= cia_pkg::CNT_W'(live_next);
      rsp_q.status     <= status;
    end
  end

  assign rsp = rsp_q;

endmodule

`default_nettype wire

// File: rtl/core/cia_checker.sv
// Port-level checker for connection_id_allocator_core, attached by bind.
// Depends on cia_pkg and connection_id_allocator_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "connection_id_allocator_core_defines.svh"

module cia_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire cia_pkg::rsp_t rsp
);

  `CIA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `CIA_ASSERT_NXT(a_busy_done, clk, rst, busy, done && !busy)
  `CIA_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `CIA_ASSERT_IMP(a_fail_no_grant, clk, rst, done && (rsp.status != cia_pkg::ST_OK), rsp.granted_id == '0)
  `CIA_ASSERT_IMP(a_none_live_zero, clk, rst, done && (rsp.status == cia_pkg::ST_NONE_LIVE), rsp.live_count == '0)

endmodule

bind connection_id_allocator_core cia_checker u_cia_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

// File: tb/sv/connection_id_allocator_core_test.sv
// Self-checking testbench for connection_id_allocator_core: directed and random
// allocate/release requests against a behavioral free-list model.
// Depends on cia_pkg and the connection_id_allocator_core RTL.
`timescale 1ns / 1ps

module connection_id_allocator_core_test;

  localparam int MAX_IDS = 256;
  localparam int RANDOM_REQUESTS = 1400;

  // Predicts each result from its request and checks the results in order.
  class grant_scoreboard;
    logic [cia_pkg::ID_W-1:0] free_ids [MAX_IDS];
    int                       free_depth;
    int                       next_fresh;
    int                       live;
    cia_pkg::rsp_t            expected_grants [$];
    int                       errors;

    function new();
      free_depth = 0;
      next_fresh = 1;
      live = 0;
      errors = 0;
    endfunction

    function cia_pkg::rsp_t predict_grant(cia_pkg::req_t r);
      cia_pkg::rsp_t e;
      int            rid;
      e.granted_id = '0;
      e.status = cia_pkg::ST_OK;
      rid = int'(r.release_id);
      if (r.action == cia_pkg::ACT_ALLOC) begin
        if (live >= MAX_IDS) begin
          e.status = cia_pkg::ST_EXHAUSTED;
        end else if (free_depth > 0) begin
          free_depth--;
          e.granted_id = free_ids[free_depth];
          live++;
        end else if (next_fresh <= MAX_IDS) begin
          e.granted_id = next_fresh[cia_pkg::ID_W-1:0];
          next_fresh++;
          live++;
        end else begin
          e.status = cia_pkg::ST_EXHAUSTED;
        end
      end else if (live == 0) begin
        e.status = cia_pkg::ST_NONE_LIVE;
      end else begin
        live--;
        if (live == 0) begin
          // last connection gone: everything restarts
          free_depth = 0;
          next_fresh = 1;
        end else if (rid >= 1 && rid <= MAX_IDS) begin
          if (rid + 1 == next_fresh) begin
            next_fresh--;
          end else if (free_depth >= MAX_IDS) begin
            e.status = cia_pkg::ST_STACK_FULL;
          end else begin
            free_ids[free_depth] = rid[cia_pkg::ID_W-1:0];
            free_depth++;
          end
        end
      end
      e.live_count = live[cia_pkg::CNT_W-1:0];
      return e;
    endfunction

    function cia_pkg::rsp_t note_request(cia_pkg::req_t r);
      cia_pkg::rsp_t e;
      e = predict_grant(r);
      expected_grants.insert(expected_grants.size(), e);
      return e;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(cia_pkg::rsp_t got);
      cia_pkg::rsp_t e;
      if (expected_grants.size() == 0) begin
        report($sformatf("unexpected result %p", got));
      end else begin
        e = expected_grants.pop_front();
        if (got.granted_id !== e.granted_id)
          report($sformatf("granted_id %0d, expected %0d", got.granted_id, e.granted_id));
        if (got.live_count !== e.live_count)
          report($sformatf("live_count %0d, expected %0d", got.live_count, e.live_count));
        if (got.status !== e.status)
          report($sformatf("status %0d, expected %0d", got.status, e.status));
      end
    endtask

    function int pending();
      return expected_grants.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  cia_pkg::req_t req;
  logic          done;
  cia_pkg::rsp_t rsp;

  grant_scoreboard sb = new();

  int held_ids [$];  // ids the stimulus believes are handed out
  int burst_left;

  connection_id_allocator_core #(.MAX_IDS(MAX_IDS)) DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send(input cia_pkg::req_t r, output cia_pkg::rsp_t e);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    e = sb.note_request(r);
    @(negedge clk);
  endtask

  task issue(input logic act, input int rid);
    cia_pkg::req_t r;
    cia_pkg::rsp_t e;
    r.action = act;
    r.release_id = rid[cia_pkg::ID_W-1:0];
    send(r, e);
    if (act == cia_pkg::ACT_ALLOC && e.status == cia_pkg::ST_OK)
      held_ids.insert(held_ids.size(), int'(e.granted_id));
    if (e.live_count == 0) held_ids.delete();
  endtask

  task random_release();
    int k;
    int idx;
    int rid;
    k = $urandom_range(99);
    if (held_ids.size() > 0 && k < 75) begin
      idx = $urandom_range(held_ids.size() - 1);
      rid = held_ids[idx];
      held_ids.delete(idx);
    end else if (held_ids.size() > 0 && k < 85) begin
      rid = held_ids[held_ids.size() - 1];
      held_ids.delete(held_ids.size() - 1);
    end else if (k < 93) begin
      rid = $urandom_range(1, MAX_IDS);
    end else begin
      rid = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_IDS + 1, 511);
    end
    issue(cia_pkg::ACT_RELEASE, rid);
  endtask

  initial begin
    int n;
    int bias;
    int len;
    int guard;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: none-live release, fresh ids, push, step-back, out-of-range ids,
    // highest id, last connection gone
    issue(cia_pkg::ACT_RELEASE, 5);
    issue(cia_pkg::ACT_ALLOC, 511);
    issue(cia_pkg::ACT_ALLOC, 0);
    issue(cia_pkg::ACT_ALLOC, 256);
    issue(cia_pkg::ACT_ALLOC, 3);
    issue(cia_pkg::ACT_RELEASE, 2);
    issue(cia_pkg::ACT_RELEASE, 4);
    issue(cia_pkg::ACT_RELEASE, 0);
    issue(cia_pkg::ACT_ALLOC, 0);
    issue(cia_pkg::ACT_ALLOC, 0);
    issue(cia_pkg::ACT_RELEASE, 511);
    issue(cia_pkg::ACT_RELEASE, 256);
    issue(cia_pkg::ACT_ALLOC, 0);
    issue(cia_pkg::ACT_RELEASE, 257);
    issue(cia_pkg::ACT_RELEASE, 3);
    issue(cia_pkg::ACT_ALLOC, 0);
    issue(cia_pkg::ACT_RELEASE, 1);
    issue(cia_pkg::ACT_RELEASE, 1);

    // random episodes with varying allocate bias; the first fills the pool
    // so exhaustion is reached
    n = 0;
    while (n < RANDOM_REQUESTS) begin
      if (n == 0) begin
        bias = 97;
        len = 320;
      end else begin
        case ($urandom_range(4))
          0: bias = 10;
          1: bias = 35;
          2: bias = 50;
          3: bias = 65;
          default: bias = 90;
        endcase
        len = $urandom_range(20, 200);
      end
      for (int i = 0; i < len && n < RANDOM_REQUESTS; i++) begin
        if ($urandom_range(99) < bias) issue(cia_pkg::ACT_ALLOC, $urandom_range(511));
        else random_release();
        n++;
      end
    end

    start <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
